>>> src/bole_pkg.sv
// bole_pkg: word types, function and status codes, and the command/status
// structs shared by the controller and datapath of the ordered list engine.
// No dependencies.
`default_nettype none

package bole_pkg;

   localparam int FUNC_W        = 3;
   localparam int VALUE_W       = 32;
   localparam int POSITION_W    = 5;
   localparam int STATUS_W      = 2;
   localparam int ENTRY_COUNT_W = 5;

   localparam logic [FUNC_W-1:0] FUNC_INSERT_AT   = 3'd0;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_AT   = 3'd1;
   localparam logic [FUNC_W-1:0] FUNC_DELETE_LAST = 3'd2;
   localparam logic [FUNC_W-1:0] FUNC_SEARCH      = 3'd3;
   localparam logic [FUNC_W-1:0] FUNC_REVERSE     = 3'd4;
   localparam logic [FUNC_W-1:0] FUNC_READ_AT     = 3'd5;

   localparam logic [STATUS_W-1:0] STATUS_DONE     = 2'd0;
   localparam logic [STATUS_W-1:0] STATUS_FULL     = 2'd1;
   localparam logic [STATUS_W-1:0] STATUS_NO_ENTRY = 2'd2;

   typedef struct packed {
      logic [FUNC_W-1:0]         func;
      logic signed [VALUE_W-1:0] item_value;
      logic [POSITION_W-1:0]     position;
   } req_word_type;

   typedef struct packed {
      logic [STATUS_W-1:0]       status;
      logic                      found;
      logic signed [VALUE_W-1:0] read_data;
      logic [ENTRY_COUNT_W-1:0]  entry_count;
   } rsp_word_type;

   // store read address: low pointer, low + 1, high pointer, high - 1
   typedef enum logic [1:0] {
      RD_LO, RD_LO_NEXT, RD_HI, RD_HI_PREV
   } rd_sel_type;

   // store write: address and data source
   typedef enum logic [1:0] {
      WR_LO_RD, WR_HI_RD, WR_HI_TEMP, WR_LO_VALUE
   } wr_sel_type;

   typedef struct packed {
      logic                start;
      logic                rd_en;
      rd_sel_type          rd_sel;
      logic                wr_en;
      wr_sel_type          wr_sel;
      logic                temp_load;
      logic                lo_inc;
      logic                hi_dec;
      logic                count_inc;
      logic                count_dec;
      logic                found_set;
      logic                rdata_load;
      logic                status_load;
      logic [STATUS_W-1:0] status_code;
      logic                rsp_load;
   } dp_cmd_type;

   typedef struct packed {
      logic [FUNC_W-1:0] func;
      logic              full;
      logic              empty;
      logic              pos_ok;
      logic              multi;
      logic              more_ins;
      logic              more_del;
      logic              more_srch;
      logic              more_rev;
      logic              match;
      logic              rsp_busy;
   } dp_sts_type;

endpackage

`default_nettype wire

>>> src/bole_ctrl.sv
// bole_ctrl: sequencer for the ordered list engine. Walks each operation
// through the one-write, one-read store of bole_dpath. Uses bole_pkg.
`default_nettype none

module bole_ctrl (
   input  wire logic                clock,
   input  wire logic                reset,
   input  wire logic                req_valid,
   output logic                     busy,
   input  wire bole_pkg::dp_sts_type sts,
   output bole_pkg::dp_cmd_type     cmd
);

   typedef enum logic [3:0] {
      ST_IDLE, ST_DISPATCH,
      ST_INS_LOOP, ST_INS_WR,
      ST_DEL_LOOP, ST_DEL_WR,
      ST_SRCH_LOOP, ST_SRCH_CMP,
      ST_REV_LOOP, ST_REV_RD_HI, ST_REV_WR_LO, ST_REV_WR_HI,
      ST_RD_WAIT, ST_RESP
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.start = 1'b1;
               state_in  = ST_DISPATCH;
            end
         end
         ST_DISPATCH: begin
            state_in = ST_RESP;
            unique case (sts.func)
               bole_pkg::FUNC_INSERT_AT: begin
                  if (sts.full) begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = bole_pkg::STATUS_FULL;
                  end else begin
                     state_in = ST_INS_LOOP;
                  end
               end
               bole_pkg::FUNC_DELETE_AT: begin
                  if (sts.pos_ok) begin
                     state_in = ST_DEL_LOOP;
                  end else begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = bole_pkg::STATUS_NO_ENTRY;
                  end
               end
               bole_pkg::FUNC_DELETE_LAST: begin
                  if (sts.empty) begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = bole_pkg::STATUS_NO_ENTRY;
                  end else begin
                     cmd.count_dec = 1'b1;
                  end
               end
               bole_pkg::FUNC_SEARCH: begin
                  state_in = ST_SRCH_LOOP;
               end
               bole_pkg::FUNC_REVERSE: begin
                  if (sts.multi) begin
                     state_in = ST_REV_LOOP;
                  end
               end
               bole_pkg::FUNC_READ_AT: begin
                  if (sts.pos_ok) begin
                     cmd.rd_en  = 1'b1;
                     cmd.rd_sel = bole_pkg::RD_LO;
                     state_in   = ST_RD_WAIT;
                  end else begin
                     cmd.status_load = 1'b1;
                     cmd.status_code = bole_pkg::STATUS_NO_ENTRY;
                  end
               end
               default: begin
                  cmd.status_load = 1'b1;
                  cmd.status_code = bole_pkg::STATUS_NO_ENTRY;
               end
            endcase
         end
         // shift words up from the tail, then drop the new value in the gap
         ST_INS_LOOP: begin
            if (sts.more_ins) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bole_pkg::RD_HI_PREV;
               state_in   = ST_INS_WR;
            end else begin
               cmd.wr_en     = 1'b1;
               cmd.wr_sel    = bole_pkg::WR_LO_VALUE;
               cmd.count_inc = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_INS_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bole_pkg::WR_HI_RD;
            cmd.hi_dec = 1'b1;
            state_in   = ST_INS_LOOP;
         end
         // close the gap by moving later words down one place
         ST_DEL_LOOP: begin
            if (sts.more_del) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bole_pkg::RD_LO_NEXT;
               state_in   = ST_DEL_WR;
            end else begin
               cmd.count_dec = 1'b1;
               state_in      = ST_RESP;
            end
         end
         ST_DEL_WR: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bole_pkg::WR_LO_RD;
            cmd.lo_inc = 1'b1;
            state_in   = ST_DEL_LOOP;
         end
         ST_SRCH_LOOP: begin
            if (sts.more_srch) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bole_pkg::RD_LO;
               cmd.lo_inc = 1'b1;
               state_in   = ST_SRCH_CMP;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_SRCH_CMP: begin
            cmd.found_set = sts.match;
            state_in      = ST_SRCH_LOOP;
         end
         // swap one pair: read lo, read hi (keep lo), write lo, write hi
         ST_REV_LOOP: begin
            if (sts.more_rev) begin
               cmd.rd_en  = 1'b1;
               cmd.rd_sel = bole_pkg::RD_LO;
               state_in   = ST_REV_RD_HI;
            end else begin
               state_in = ST_RESP;
            end
         end
         ST_REV_RD_HI: begin
            cmd.rd_en     = 1'b1;
            cmd.rd_sel    = bole_pkg::RD_HI;
            cmd.temp_load = 1'b1;
            state_in      = ST_REV_WR_LO;
         end
         ST_REV_WR_LO: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bole_pkg::WR_LO_RD;
            state_in   = ST_REV_WR_HI;
         end
         ST_REV_WR_HI: begin
            cmd.wr_en  = 1'b1;
            cmd.wr_sel = bole_pkg::WR_HI_TEMP;
            cmd.lo_inc = 1'b1;
            cmd.hi_dec = 1'b1;
            state_in   = ST_REV_LOOP;
         end
         ST_RD_WAIT: begin
            cmd.rdata_load = 1'b1;
            state_in       = ST_RESP;
         end
         ST_RESP: begin
            if (!sts.rsp_busy) begin
               cmd.rsp_load = 1'b1;
               state_in     = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign busy = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

>>> src/bole_dpath.sv
// bole_dpath: list store (single write, single registered read port),
// entry count, walking pointers and the result register.
// Driven by bole_ctrl through bole_pkg::dp_cmd_type.
`default_nettype none

module bole_dpath #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire bole_pkg::req_word_type req_data,
   input  wire bole_pkg::dp_cmd_type   cmd,
   output bole_pkg::dp_sts_type        sts,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bole_pkg::rsp_word_type      rsp_data
);

   localparam int AW = $clog2(CAPACITY);
   localparam int CW = $clog2(CAPACITY + 1);
   localparam int PW = CW + bole_pkg::POSITION_W;
   localparam int XW = DATA_WIDTH + bole_pkg::VALUE_W;

   logic [DATA_WIDTH-1:0] mem [CAPACITY];

   bole_pkg::req_word_type      req_ff;
   logic [CW-1:0]               count_ff, count_in;
   logic [CW-1:0]               lo_ff, lo_in;
   logic [CW-1:0]               hi_ff, hi_in;
   logic [DATA_WIDTH-1:0]       temp_ff;
   logic [DATA_WIDTH-1:0]       rd_data_ff;
   logic [bole_pkg::STATUS_W-1:0] status_ff;
   logic                        found_ff;
   logic signed [bole_pkg::VALUE_W-1:0] rdata_ff;
   logic                        rsp_valid_ff;
   bole_pkg::rsp_word_type      rsp_data_ff;

   logic [PW-1:0]         pos_new_x, pos_cur_x, count_x;
   logic [CW-1:0]         start_at;
   logic [CW-1:0]         lo_next, hi_prev;
   logic [XW-1:0]         value_x, entry_x;
   logic [DATA_WIDTH-1:0] value_w;
   logic [CW-1:0]         rd_ptr, wr_ptr;
   logic [DATA_WIDTH-1:0] wr_data;

   assign count_x   = PW'(count_ff);
   assign pos_new_x = PW'(req_data.position);
   assign pos_cur_x = PW'(req_ff.position);
   assign start_at  = (pos_new_x < count_x) ? pos_new_x[CW-1:0] : count_ff;
   assign lo_next   = lo_ff + 1'b1;
   assign hi_prev   = hi_ff - 1'b1;

   // value kept as its low DATA_WIDTH bits, zero above 32
   assign value_x = XW'($unsigned(req_ff.item_value));
   assign value_w = value_x[DATA_WIDTH-1:0];
   assign entry_x = XW'(rd_data_ff);

   always_comb begin
      case (cmd.rd_sel)
         bole_pkg::RD_LO:      rd_ptr = lo_ff;
         bole_pkg::RD_LO_NEXT: rd_ptr = lo_next;
         bole_pkg::RD_HI:      rd_ptr = hi_ff;
         default:              rd_ptr = hi_prev;
      endcase
      case (cmd.wr_sel)
         bole_pkg::WR_LO_RD: begin
            wr_ptr  = lo_ff;
            wr_data = rd_data_ff;
         end
         bole_pkg::WR_HI_RD: begin
            wr_ptr  = hi_ff;
            wr_data = rd_data_ff;
         end
         bole_pkg::WR_HI_TEMP: begin
            wr_ptr  = hi_ff;
            wr_data = temp_ff;
         end
         default: begin
            wr_ptr  = lo_ff;
            wr_data = value_w;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.wr_en) begin
         mem[wr_ptr[AW-1:0]] <= wr_data;
      end
      if (cmd.rd_en) begin
         rd_data_ff <= mem[rd_ptr[AW-1:0]];
      end
   end

   always_comb begin
      count_in = count_ff;
      if (cmd.count_inc) begin
         count_in = count_ff + 1'b1;
      end else if (cmd.count_dec) begin
         count_in = count_ff - 1'b1;
      end
      lo_in = lo_ff;
      hi_in = hi_ff;
      if (cmd.start) begin
         if (req_data.func == bole_pkg::FUNC_SEARCH ||
             req_data.func == bole_pkg::FUNC_REVERSE) begin
            lo_in = '0;
         end else begin
            lo_in = start_at;
         end
         // reverse walks from the last entry; insert shifts into the slot past it
         hi_in = (req_data.func == bole_pkg::FUNC_REVERSE) ? count_ff - 1'b1 : count_ff;
      end else begin
         if (cmd.lo_inc) begin
            lo_in = lo_next;
         end
         if (cmd.hi_dec) begin
            hi_in = hi_prev;
         end
      end
   end

   always_ff @(posedge clock) begin
      lo_ff <= lo_in;
      hi_ff <= hi_in;
      if (cmd.start) begin
         req_ff   <= req_data;
         status_ff <= bole_pkg::STATUS_DONE;
         found_ff <= 1'b0;
         rdata_ff <= '0;
      end else begin
         if (cmd.status_load) begin
            status_ff <= cmd.status_code;
         end
         if (cmd.found_set) begin
            found_ff <= 1'b1;
         end
         if (cmd.rdata_load) begin
            rdata_ff <= $signed(entry_x[bole_pkg::VALUE_W-1:0]);
         end
      end
      if (cmd.temp_load) begin
         temp_ff <= rd_data_ff;
      end
      if (cmd.rsp_load) begin
         rsp_data_ff.status      <= status_ff;
         rsp_data_ff.found       <= found_ff;
         rsp_data_ff.read_data   <= rdata_ff;
         rsp_data_ff.entry_count <= count_x[bole_pkg::ENTRY_COUNT_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         count_ff     <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         count_ff <= count_in;
         if (cmd.rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   assign sts.func      = req_ff.func;
   assign sts.full      = (count_x >= PW'(CAPACITY));
   assign sts.empty     = (count_ff == '0);
   assign sts.pos_ok    = (pos_cur_x < count_x);
   assign sts.multi     = (count_ff > CW'(1));
   assign sts.more_ins  = (hi_ff > lo_ff);
   assign sts.more_del  = (lo_next < count_ff);
   assign sts.more_srch = (lo_ff < count_ff);
   assign sts.more_rev  = (lo_ff < hi_ff);
   assign sts.match     = (rd_data_ff == value_w);
   assign sts.rsp_busy  = rsp_valid_ff && rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

endmodule

`default_nettype wire

>>> src/bounded_ordered_list_engine.sv
// bounded_ordered_list_engine: top level of the ordered list engine.
// Instantiates bole_ctrl and bole_dpath; types from bole_pkg.
//
//   channel  direction  handshake             word
//   req      in         req_valid/req_stall   bole_pkg::req_word_type
//   rsp      out        rsp_valid/rsp_stall   bole_pkg::rsp_word_type
//
// One operation at a time; the store has one write and one registered read
// port, so each moved word takes a read and then a write, and a reversed pair
// two reads and two writes. Insert and delete shift the words past the
// position, search reads every entry, reverse swaps pairs from both ends.
// A word is accepted again the cycle after the result is loaded, even while
// rsp_stall holds it. Reset clears the count; store contents are left as is.
`default_nettype none

module bounded_ordered_list_engine #(
   parameter int CAPACITY   = 16,
   parameter int DATA_WIDTH = 32
) (
   input  wire logic                   clock,
   input  wire logic                   reset,
   input  wire logic                   req_valid,
   output logic                        req_stall,
   input  wire bole_pkg::req_word_type req_data,
   output logic                        rsp_valid,
   input  wire logic                   rsp_stall,
   output bole_pkg::rsp_word_type      rsp_data
);

   bole_pkg::dp_cmd_type cmd;
   bole_pkg::dp_sts_type sts;
   logic                 busy;

   bole_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .busy      (busy),
      .sts       (sts),
      .cmd       (cmd)
   );

   bole_dpath #(
      .CAPACITY   (CAPACITY),
      .DATA_WIDTH (DATA_WIDTH)
   ) u_dpath (
      .clock     (clock),
      .reset     (reset),
      .req_data  (req_data),
      .cmd       (cmd),
      .sts       (sts),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   assign req_stall = busy;

   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("engine not busy after taking a word");

   a_status_code: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> (rsp_data.status == bole_pkg::STATUS_DONE ||
                     rsp_data.status == bole_pkg::STATUS_FULL ||
                     rsp_data.status == bole_pkg::STATUS_NO_ENTRY))
      else $error("result carries an unknown status");

   a_full_count: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.status == bole_pkg::STATUS_FULL) |->
      (rsp_data.entry_count == bole_pkg::ENTRY_COUNT_W'(CAPACITY)))
      else $error("full status with list not at capacity");

   a_found_only_done: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.found) |-> (rsp_data.status == bole_pkg::STATUS_DONE))
      else $error("found set on a failed operation");

endmodule

`default_nettype wire

>>> bench/bounded_ordered_list_engine_test.sv
// Self-checking bench for bounded_ordered_list_engine: directed corner cases, a full list,
// a long output hold-off and about 1200 random list operations against an in-bench list model.
// Depends on bole_pkg and the engine RTL only.
`timescale 1ns / 100ps

module bounded_ordered_list_engine_test;

   localparam int LIST_CAPACITY  = 16;
   localparam int RANDOM_WORDS   = 1200;
   localparam int PHASE_WORDS    = 120;
   localparam int HOLD_CYCLES    = 300;
   localparam int IDLE_LIMIT     = 5000;
   localparam int SETTLE_CYCLES  = 60;
   localparam int REPORT_LINES   = 20;

   // func codes with no operation behind them
   localparam logic [bole_pkg::FUNC_W-1:0] FUNC_SPARE_A = 3'd6;
   localparam logic [bole_pkg::FUNC_W-1:0] FUNC_SPARE_B = 3'd7;

   typedef enum int { BIAS_FILL, BIAS_DRAIN, BIAS_MIXED } op_bias_type;

   logic                   clock = 1'b0;
   logic                   reset = 1'b1;
   logic                   req_valid = 1'b0;
   logic                   req_stall;
   bole_pkg::req_word_type req_data = '0;
   logic                   rsp_valid;
   logic                   rsp_stall = 1'b0;
   bole_pkg::rsp_word_type rsp_data;

   logic         quiet = 1'b0;
   logic         hold_request = 1'b0;
   int           hold_left;

   // list model
   logic signed [bole_pkg::VALUE_W-1:0] list_entries [LIST_CAPACITY];
   int                                  list_len = 0;
   bole_pkg::rsp_word_type              pending_results[$];

   int mismatch_count = 0;
   int op_count [8];
   int full_refusals = 0;
   int found_hits = 0;
   int full_visits = 0;
   int empty_visits = 0;

   bounded_ordered_list_engine #(
      .CAPACITY(LIST_CAPACITY),
      .DATA_WIDTH(bole_pkg::VALUE_W)
   ) DUT (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data(req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data(rsp_data)
   );

   initial begin
      forever #5 clock = ~clock;
   end

   // applies one operation to the list model and returns the word it should produce
   function automatic bole_pkg::rsp_word_type apply_list_op(input bole_pkg::req_word_type w);
      bole_pkg::rsp_word_type r;
      int at;
      int i;
      logic signed [bole_pkg::VALUE_W-1:0] t;
      r = '0;
      r.status = bole_pkg::STATUS_DONE;
      op_count[w.func]++;
      case (w.func)
         bole_pkg::FUNC_INSERT_AT: begin
            if (list_len >= LIST_CAPACITY) begin
               r.status = bole_pkg::STATUS_FULL;
               full_refusals++;
            end else begin
               at = (int'(w.position) < list_len) ? int'(w.position) : list_len;
               for (i = list_len; i > at; i--) list_entries[i] = list_entries[i-1];
               list_entries[at] = w.item_value;
               list_len++;
               if (list_len == LIST_CAPACITY) full_visits++;
            end
         end
         bole_pkg::FUNC_DELETE_AT: begin
            if (int'(w.position) < list_len) begin
               for (i = int'(w.position); i + 1 < list_len; i++)
                  list_entries[i] = list_entries[i+1];
               list_len--;
               if (list_len == 0) empty_visits++;
            end else begin
               r.status = bole_pkg::STATUS_NO_ENTRY;
            end
         end
         bole_pkg::FUNC_DELETE_LAST: begin
            if (list_len > 0) begin
               list_len--;
               if (list_len == 0) empty_visits++;
            end else begin
               r.status = bole_pkg::STATUS_NO_ENTRY;
            end
         end
         bole_pkg::FUNC_SEARCH: begin
            for (i = 0; i < list_len; i++) begin
               if (list_entries[i] == w.item_value) r.found = 1'b1;
            end
            if (r.found) found_hits++;
         end
         bole_pkg::FUNC_REVERSE: begin
            for (i = 0; i < list_len / 2; i++) begin
               t = list_entries[i];
               list_entries[i] = list_entries[list_len-1-i];
               list_entries[list_len-1-i] = t;
            end
         end
         bole_pkg::FUNC_READ_AT: begin
            if (int'(w.position) < list_len) r.read_data = list_entries[w.position];
            else r.status = bole_pkg::STATUS_NO_ENTRY;
         end
         default: begin
            r.status = bole_pkg::STATUS_NO_ENTRY;
         end
      endcase
      r.entry_count = list_len[bole_pkg::ENTRY_COUNT_W-1:0];
      return r;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      if (mismatch_count < REPORT_LINES)
         $display("%0t: %s: got %0h, expected %0h", $realtime, what, got, want);
      mismatch_count++;
   endtask

   // offers one word; returns right after the edge that took it, valid left high
   task automatic offer_word(input bole_pkg::req_word_type w);
      while (!quiet && $urandom_range(99) < 10) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_data <= w;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      pending_results.push_back(apply_list_op(w));
   endtask

   task automatic offer_op(input logic [bole_pkg::FUNC_W-1:0] f,
                           input logic signed [bole_pkg::VALUE_W-1:0] v,
                           input logic [bole_pkg::POSITION_W-1:0] p);
      bole_pkg::req_word_type w;
      w.func = f;
      w.item_value = v;
      w.position = p;
      offer_word(w);
   endtask

   // sender stops and waits for every outstanding result
   task automatic wait_for_results;
      req_valid <= 1'b0;
      @(posedge clock);
      while (pending_results.size() != 0) @(posedge clock);
   endtask

   function automatic logic signed [bole_pkg::VALUE_W-1:0] pick_value;
      int roll;
      roll = $urandom_range(99);
      if (roll < 35 && list_len > 0) return list_entries[$urandom_range(list_len - 1)];
      if (roll < 45) return $urandom_range(1) ? 32'sh7fffffff : 32'sh80000000;
      if (roll < 65) return $signed(32'($urandom_range(7))) - 32'sd4;
      return $signed($urandom);
   endfunction

   function automatic logic [bole_pkg::POSITION_W-1:0] pick_position;
      int roll;
      roll = $urandom_range(99);
      if (roll < 70) return bole_pkg::POSITION_W'($urandom_range(list_len));
      if (roll < 90) return bole_pkg::POSITION_W'($urandom_range(LIST_CAPACITY));
      return bole_pkg::POSITION_W'($urandom_range(31));
   endfunction

   function automatic logic [bole_pkg::FUNC_W-1:0] pick_func(input op_bias_type bias);
      int roll;
      int ins_w;
      int del_w;
      roll = $urandom_range(99);
      ins_w = (bias == BIAS_FILL) ? 55 : (bias == BIAS_DRAIN) ? 20 : 35;
      del_w = (bias == BIAS_DRAIN) ? 45 : 15;
      if (roll < ins_w) return bole_pkg::FUNC_INSERT_AT;
      roll -= ins_w;
      if (roll < del_w * 2 / 3) return bole_pkg::FUNC_DELETE_AT;
      roll -= del_w * 2 / 3;
      if (roll < del_w / 3) return bole_pkg::FUNC_DELETE_LAST;
      roll -= del_w / 3;
      if (roll < 2) return $urandom_range(1) ? FUNC_SPARE_A : FUNC_SPARE_B;
      roll -= 2;
      if (roll < 6) return bole_pkg::FUNC_REVERSE;
      if (roll < 22) return bole_pkg::FUNC_SEARCH;
      return bole_pkg::FUNC_READ_AT;
   endfunction

   function automatic bole_pkg::req_word_type random_word(input op_bias_type bias);
      bole_pkg::req_word_type w;
      w.func = pick_func(bias);
      w.item_value = pick_value();
      w.position = pick_position();
      return w;
   endfunction

   task automatic test_corner_cases;
      offer_op(bole_pkg::FUNC_DELETE_LAST, '0, '0);
      offer_op(bole_pkg::FUNC_DELETE_AT, '0, '0);
      offer_op(bole_pkg::FUNC_READ_AT, '0, '0);
      offer_op(bole_pkg::FUNC_SEARCH, '0, '0);
      offer_op(bole_pkg::FUNC_REVERSE, '0, '0);
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh7fffffff, 5'd31);   // past the end: appended
      offer_op(bole_pkg::FUNC_REVERSE, '0, '0);                   // single word, unchanged
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh80000000, 5'd0);
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh0, 5'd1);
      offer_op(bole_pkg::FUNC_INSERT_AT, -32'sd1, 5'd16);
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh55555555, 5'd2);
      offer_op(bole_pkg::FUNC_SEARCH, 32'sh80000000, 5'd31);
      offer_op(bole_pkg::FUNC_SEARCH, 32'sh12345678, 5'd0);
      offer_op(bole_pkg::FUNC_REVERSE, 32'shffffffff, 5'd31);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd0);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd3);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd4);                 // the last word of the list
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd31);
      offer_op(bole_pkg::FUNC_DELETE_AT, '0, 5'd31);
      offer_op(bole_pkg::FUNC_DELETE_AT, '0, 5'd3);
      offer_op(bole_pkg::FUNC_DELETE_AT, '0, 5'd0);
      offer_op(FUNC_SPARE_A, 32'sh7fffffff, 5'd1);
      offer_op(FUNC_SPARE_B, 32'sh80000000, 5'd0);
      offer_op(bole_pkg::FUNC_DELETE_LAST, '0, '0);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd0);
   endtask

   task automatic test_full_list;
      while (list_len < LIST_CAPACITY)
         offer_op(bole_pkg::FUNC_INSERT_AT, pick_value(), pick_position());
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh1, 5'd0);           // refused on a full list
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh2, 5'd31);
      offer_op(bole_pkg::FUNC_REVERSE, '0, '0);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd15);
      offer_op(bole_pkg::FUNC_READ_AT, '0, 5'd16);
      offer_op(bole_pkg::FUNC_SEARCH, list_entries[LIST_CAPACITY-1], 5'd0);
      offer_op(bole_pkg::FUNC_DELETE_AT, '0, 5'd15);
      offer_op(bole_pkg::FUNC_INSERT_AT, 32'sh3, 5'd8);
      wait_for_results();
   endtask

   // receiver holds off while the sender keeps offering, so the engine backs up
   task automatic test_output_hold_off;
      int n;
      hold_request <= 1'b1;
      @(posedge clock);
      hold_request <= 1'b0;
      for (n = 0; n < 12; n++) offer_word(random_word(BIAS_MIXED));
      wait_for_results();
   endtask

   task automatic test_random_traffic;
      int sent;
      int phase;
      int n;
      sent = 0;
      phase = 0;
      while (sent < RANDOM_WORDS) begin
         quiet <= (phase == 4);
         for (n = 0; n < PHASE_WORDS && sent < RANDOM_WORDS; n++) begin
            offer_word(random_word(op_bias_type'(phase % 3)));
            sent++;
         end
         if (phase % 2 == 1) wait_for_results();
         phase++;
      end
      quiet <= 1'b0;
   endtask

   // receiver: random stalls, a long hold-off on request, none while quiet
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
         hold_left <= 0;
      end else if (hold_request) begin
         rsp_stall <= 1'b1;
         hold_left <= HOLD_CYCLES;
      end else if (hold_left != 0) begin
         rsp_stall <= 1'b1;
         hold_left <= hold_left - 1;
      end else begin
         rsp_stall <= !quiet && ($urandom_range(99) < 10);
      end
   end

   always @(posedge clock) begin
      bole_pkg::rsp_word_type want;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (pending_results.size() == 0) begin
            report_mismatch("result word with nothing outstanding",
                            32'(rsp_data.entry_count), 32'd0);
         end else begin
            want = pending_results.pop_front();
            if (rsp_data.status !== want.status)
               report_mismatch("status", 32'(rsp_data.status), 32'(want.status));
            if (rsp_data.found !== want.found)
               report_mismatch("found", 32'(rsp_data.found), 32'(want.found));
            if (rsp_data.read_data !== want.read_data)
               report_mismatch("read_data", 32'(rsp_data.read_data), 32'(want.read_data));
            if (rsp_data.entry_count !== want.entry_count)
               report_mismatch("entry_count", 32'(rsp_data.entry_count),
                               32'(want.entry_count));
         end
      end
   end

   // watchdog: too long without any word moving on either side
   initial begin
      int idle_cycles;
      idle_cycles = 0;
      while (idle_cycles < IDLE_LIMIT) begin
         @(posedge clock);
         if (reset || (req_valid && !req_stall) || (rsp_valid && !rsp_stall)) idle_cycles = 0;
         else idle_cycles++;
      end
      $display("watchdog: no word moved for %0d cycles", IDLE_LIMIT);
      $display("SCOREBOARD MISMATCH");
      $finish;
   end

   initial begin
      foreach (op_count[k]) op_count[k] = 0;
      repeat (8) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_corner_cases();
      test_full_list();
      test_output_hold_off();
      test_random_traffic();
      wait_for_results();
      repeat (SETTLE_CYCLES) @(posedge clock);
      $display("ops: insert %0d, delete_at %0d, delete_last %0d, search %0d,",
               op_count[bole_pkg::FUNC_INSERT_AT], op_count[bole_pkg::FUNC_DELETE_AT],
               op_count[bole_pkg::FUNC_DELETE_LAST], op_count[bole_pkg::FUNC_SEARCH],
               " reverse %0d, read %0d, spare %0d",
               op_count[bole_pkg::FUNC_REVERSE], op_count[bole_pkg::FUNC_READ_AT],
               op_count[FUNC_SPARE_A] + op_count[FUNC_SPARE_B]);
      $display("list filled %0d times, emptied %0d times; %0d inserts refused, %0d searches hit",
               full_visits, empty_visits, full_refusals, found_hits);
      if (mismatch_count == 0 && pending_results.size() == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule
